// ===== rtl/ssds_pkg.sv =====
// Shared types and constants for the shadow stack delta snapshot block.
package ssds_pkg;

	localparam int unsigned CNT_W   = 6;
	localparam int unsigned ID_W    = 32;
	localparam int unsigned TS_W    = 63;
	localparam int unsigned S_DATA_W = 96;
	localparam int unsigned M_DATA_W = 112;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_SNAP = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_DEPTH = 2'd0,
		KIND_TRACE = 2'd1,
		KIND_TRAIL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT,
		ST_TRAIL
	} st_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  id;
		logic [TS_W-1:0]  ts;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

endpackage

// ===== rtl/ssds_front.sv =====
// Input side: accepts stream transfers, drops unused codes, queues commands.
module ssds_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ssds_pkg::S_DATA_W-1:0]   s_tdata,  // call_id[31:0], timestamp[94:32], pad
	input  logic [1:0]                      s_tuser,  // operation[1:0]
	output ssds_pkg::cmd_req_t              cmd,
	input  logic                            cmd_ready
);

	ssds_pkg::cmd_t q_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           accept;
	logic           keep;
	logic           deq;
	ssds_pkg::cmd_t in_cmd;

	assign s_tready = (fill_q != 2'd2);
	assign accept   = s_tvalid & s_tready;
	assign keep     = accept && (s_tuser == ssds_pkg::OP_PUSH || s_tuser == ssds_pkg::OP_POP ||
		s_tuser == ssds_pkg::OP_SNAP);
	assign deq      = cmd.valid & cmd_ready;

	assign in_cmd.op = ssds_pkg::op_t'(s_tuser);
	assign in_cmd.id = s_tdata[ssds_pkg::ID_W-1:0];
	assign in_cmd.ts = s_tdata[ssds_pkg::ID_W +: ssds_pkg::TS_W];

	assign cmd.valid = (fill_q != 2'd0);
	assign cmd.cmd   = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			q_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (keep) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({keep, deq})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/ssds_back.sv =====
// Execution side: stack storage, snapshot walker and output register.
module ssds_back #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ssds_pkg::cmd_req_t              cmd,
	output logic                            cmd_ready,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ssds_pkg::M_DATA_W-1:0]   m_tdata,
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast
);

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = ssds_pkg::CNT_W;

	logic [ssds_pkg::ID_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]          new_q;
	logic [ssds_pkg::ID_W-1:0] rd_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             pos_q;
	logic [ssds_pkg::TS_W-1:0] ts_q;

	ssds_pkg::st_t state_q, state_d;

	logic                      m_valid_q;
	ssds_pkg::kind_t           kind_q, kind_d;
	logic [ssds_pkg::ID_W-1:0] id_q, id_d;
	logic [CW-1:0]             depth_q, depth_d;
	logic [CW-1:0]             off_q, off_d;
	logic [ssds_pkg::TS_W-1:0] stamp_q, stamp_d;
	ssds_pkg::err_t            err_q, err_d;
	logic                      last_q, last_d;

	logic          out_free;
	logic          load_out;
	logic          cnt_inc;
	logic          cnt_dec;
	logic          snap_start;
	logic          walk_step;
	logic          full;
	logic [CW-1:0] pos_m1;
	logic [IW-1:0] wr_idx;
	logic [IW-1:0] walk_idx;
	logic          top_new;

	assign out_free = !m_valid_q || m_tready;
	assign full     = (count_q == CW'(DEPTH));
	assign pos_m1   = pos_q - CW'(1);
	assign wr_idx   = count_q[IW-1:0];
	assign walk_idx = pos_m1[IW-1:0];
	assign top_new  = (pos_q != '0) && new_q[walk_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		load_out   = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		snap_start = 1'b0;
		walk_step  = 1'b0;
		kind_d     = ssds_pkg::KIND_DEPTH;
		id_d       = '0;
		depth_d    = count_q;
		off_d      = '0;
		stamp_d    = '0;
		err_d      = ssds_pkg::ERR_OK;
		last_d     = 1'b1;
		unique case (state_q)
			ssds_pkg::ST_IDLE: begin
				if (cmd.valid && out_free) begin
					cmd_ready = 1'b1;
					unique case (cmd.cmd.op)
						ssds_pkg::OP_PUSH: begin
							load_out = 1'b1;
							if (full) begin
								err_d = ssds_pkg::ERR_FULL;
							end else begin
								cnt_inc = 1'b1;
								depth_d = count_q + CW'(1);
							end
						end
						ssds_pkg::OP_POP: begin
							load_out = 1'b1;
							if (count_q == '0) begin
								err_d = ssds_pkg::ERR_EMPTY;
							end else begin
								cnt_dec = 1'b1;
								depth_d = count_q - CW'(1);
							end
						end
						ssds_pkg::OP_SNAP: begin
							snap_start = 1'b1;
							state_d    = ssds_pkg::ST_WALK;
						end
						default: begin
							cmd_ready = 1'b1;
						end
					endcase
				end
			end
			ssds_pkg::ST_WALK: begin
				if (top_new) begin
					walk_step = 1'b1;
					state_d   = ssds_pkg::ST_EMIT;
				end else begin
					state_d = ssds_pkg::ST_TRAIL;
				end
			end
			ssds_pkg::ST_EMIT: begin
				kind_d = ssds_pkg::KIND_TRACE;
				id_d   = rd_q;
				last_d = 1'b0;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ssds_pkg::ST_WALK;
				end
			end
			ssds_pkg::ST_TRAIL: begin
				kind_d  = ssds_pkg::KIND_TRAIL;
				off_d   = pos_q;
				stamp_d = ts_q;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ssds_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ssds_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_inc) begin
			mem[wr_idx] <= cmd.cmd.id;
		end
		if (walk_step) begin
			rd_q <= mem[walk_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_inc) begin
			new_q[wr_idx] <= 1'b1;
		end
		if (walk_step) begin
			new_q[walk_idx] <= 1'b0;
		end
		if (snap_start) begin
			ts_q <= cmd.cmd.ts;
		end
		if (load_out) begin
			kind_q  <= kind_d;
			id_q    <= id_d;
			depth_q <= depth_d;
			off_q   <= off_d;
			stamp_q <= stamp_d;
			err_q   <= err_d;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pos_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (snap_start) begin
				pos_q <= count_q;
			end else if (walk_step) begin
				pos_q <= pos_m1;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {3'b000, err_q, stamp_q, off_q, depth_q, id_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack depth beyond capacity");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ssds_pkg::ST_IDLE |-> pos_q <= count_q)
		else $error("walk position above depth");

	a_trace_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && kind_q == ssds_pkg::KIND_TRACE |-> !last_q)
		else $error("trace entry marked last");

	a_err_depth_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && err_q != ssds_pkg::ERR_OK |-> kind_q == ssds_pkg::KIND_DEPTH)
		else $error("error flag on non depth result");

	a_count_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ssds_pkg::ST_IDLE |=> $stable(count_q))
		else $error("depth changed during snapshot");

endmodule

// ===== rtl/shadow_stack_delta_snapshot_core.sv =====
// Top level of the shadow call stack with delta snapshots.
//
// Input channel s_*: one transfer per command. s_tuser is the operation
// (push, pop, snapshot; code 3 is taken and dropped). s_tdata carries the
// method id for push and the timestamp for snapshot.
// Output channel m_*: push and pop give one depth update each. A snapshot
// gives one trace entry per new entry walked from the top, then a trailer
// with offset and timestamp; m_tlast marks the final result of a command.
// A push or pop result is registered in the command queue, then in the output register.
// Push and pop sustain one per cycle while the output register is taken; a
// snapshot holds the executor through a walk and an emit state per emitted
// entry, as the id memory read is registered, then a walk and a trailer state.
// A two-entry command queue lets input transfers continue while the
// executor walks or while m_tready is low; results wait in the output
// register, and the executor stalls until it is taken.
// Reset clears the depth, the queue and the output valid; the id memory
// and new marks need no clearing and the block is ready at once.
module shadow_stack_delta_snapshot_core #(
	parameter int unsigned DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ssds_pkg::S_DATA_W-1:0]   s_tdata,  // call_id[31:0], timestamp[94:32], pad
	input  logic [1:0]                      s_tuser,  // operation[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ssds_pkg::M_DATA_W-1:0]   m_tdata,  // trace_id[31:0], new_depth[37:32],
	                                                  // offset[43:38], stamp[106:44],
	                                                  // error[108:107], pad
	output logic [1:0]                      m_tuser,  // kind[1:0]
	output logic                            m_tlast
);

	ssds_pkg::cmd_req_t cmd;
	logic               cmd_ready;

	ssds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	ssds_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== test/tb_shadow_stack_delta_snapshot_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the shadow call stack with delta snapshots.
module tb_shadow_stack_delta_snapshot_core;

	localparam int STACK_DEPTH = 32;
	localparam int NUM_ITEMS   = 230;
	localparam int LIMIT       = 2000000;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef struct packed {
		ssds_pkg::kind_t kind;
		logic [31:0]     trace_id;
		logic [5:0]      new_depth;
		logic [5:0]      offset;
		logic [62:0]     stamp;
		ssds_pkg::err_t  error;
		logic            last;
	} result_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] id;
		logic [62:0] ts;
		logic        typed;
		result_t     res;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [ssds_pkg::S_DATA_W-1:0] s_tdata;
	logic [1:0]                    s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [ssds_pkg::M_DATA_W-1:0] m_tdata;
	logic [1:0]                    m_tuser;
	logic                          m_tlast;

	logic [31:0] stk_id [STACK_DEPTH];
	bit          stk_new [STACK_DEPTH];
	int          stk_depth;
	result_t     pending_results[$];
	stim_row_t   dir_rows[$];
	int          mismatches;
	bit          src_steady;

	shadow_stack_delta_snapshot_core #(
		.DEPTH(STACK_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	function automatic logic [31:0] rand_id();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return 32'hFFFF_FFFF;
		if (r == 1)
			return 32'd0;
		return $urandom;
	endfunction

	function automatic logic [62:0] rand_stamp();
		int r;
		logic [63:0] w;
		r = $urandom_range(15);
		w = {$urandom, $urandom};
		if (r == 0)
			return {63{1'b1}};
		if (r == 1)
			return 63'd0;
		return w[62:0];
	endfunction

	function automatic result_t depth_res(int d, ssds_pkg::err_t e);
		result_t r;
		r = '0;
		r.kind = ssds_pkg::KIND_DEPTH;
		r.new_depth = 6'(d);
		r.error = e;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic result_t trail_res(int d, int off, logic [62:0] ts);
		result_t r;
		r = '0;
		r.kind = ssds_pkg::KIND_TRAIL;
		r.new_depth = 6'(d);
		r.offset = 6'(off);
		r.stamp = ts;
		r.error = ssds_pkg::ERR_OK;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void add_exp(input result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void add_row(input logic [1:0] op, input logic [31:0] id,
			input logic [62:0] ts, input logic typed, input result_t res);
		stim_row_t row;
		row.op = op;
		row.id = id;
		row.ts = ts;
		row.typed = typed;
		row.res = res;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic void show_res(input string tag, input result_t r);
		$display("%s kind=%0d id=%h depth=%0d off=%0d stamp=%h err=%0d last=%b",
			tag, r.kind, r.trace_id, r.new_depth, r.offset, r.stamp, r.error, r.last);
	endfunction

	// Advance the shadow stack by one command and queue the results it yields.
	task automatic stack_apply(input logic [1:0] op, input logic [31:0] id,
			input logic [62:0] ts);
		result_t t;
		int pos;
		case (op)
			ssds_pkg::OP_PUSH: begin
				if (stk_depth >= STACK_DEPTH) begin
					add_exp(depth_res(stk_depth, ssds_pkg::ERR_FULL));
				end else begin
					stk_id[stk_depth] = id;
					stk_new[stk_depth] = 1'b1;
					stk_depth++;
					add_exp(depth_res(stk_depth, ssds_pkg::ERR_OK));
				end
			end
			ssds_pkg::OP_POP: begin
				if (stk_depth == 0) begin
					add_exp(depth_res(0, ssds_pkg::ERR_EMPTY));
				end else begin
					stk_depth--;
					add_exp(depth_res(stk_depth, ssds_pkg::ERR_OK));
				end
			end
			ssds_pkg::OP_SNAP: begin
				pos = stk_depth;
				while (pos > 0 && stk_new[pos-1]) begin
					pos--;
					t = '0;
					t.kind = ssds_pkg::KIND_TRACE;
					t.trace_id = stk_id[pos];
					t.new_depth = 6'(stk_depth);
					t.error = ssds_pkg::ERR_OK;
					t.last = 1'b0;
					add_exp(t);
					stk_new[pos] = 1'b0;
				end
				add_exp(trail_res(stk_depth, pos, ts));
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_cmd(input logic [1:0] op, input logic [31:0] id,
			input logic [62:0] ts, input logic typed, input result_t typed_res);
		int gap;
		if ($urandom_range(24) == 0)
			src_steady = !src_steady;
		gap = src_steady ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, ts, id};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		stack_apply(op, id, ts);
		if (typed)
			pending_results[pending_results.size() - 1] = typed_res;
	endtask

	task automatic send_rand(input int mode, inout int sent);
		int r;
		int p_push;
		int p_pop;
		int p_snap;
		logic [1:0] op;
		r = $urandom_range(99);
		case (mode)
			0: begin
				p_push = 70;
				p_pop = 80;
				p_snap = 97;
			end
			1: begin
				p_push = 15;
				p_pop = 80;
				p_snap = 97;
			end
			2: begin
				p_push = 45;
				p_pop = 60;
				p_snap = 97;
			end
			default: begin
				p_push = 35;
				p_pop = 65;
				p_snap = 92;
			end
		endcase
		if (r < p_push)
			op = ssds_pkg::OP_PUSH;
		else if (r < p_pop)
			op = ssds_pkg::OP_POP;
		else if (r < p_snap)
			op = ssds_pkg::OP_SNAP;
		else
			op = OP_NONE;
		send_cmd(op, rand_id(), rand_stamp(), 1'b0, '0);
		sent++;
	endtask

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = ssds_pkg::kind_t'(m_tuser);
			got.trace_id = m_tdata[31:0];
			got.new_depth = m_tdata[37:32];
			got.offset = m_tdata[43:38];
			got.stamp = m_tdata[106:44];
			got.error = ssds_pkg::err_t'(m_tdata[108:107]);
			got.last = m_tlast;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					show_res("unexpected result:", got);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.trace_id !== want.trace_id ||
						got.new_depth !== want.new_depth || got.offset !== want.offset ||
						got.stamp !== want.stamp || got.error !== want.error ||
						got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						show_res("mismatch: exp", want);
						show_res("          got", got);
					end
				end
			end
		end
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat (($urandom_range(11) == 0) ? $urandom_range(200, 60) : $urandom_range(8, 1))
				@(negedge clk);
			stall = idle_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int sent;
		int mode;
		int len;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		stk_depth = 0;
		mismatches = 0;
		src_steady = 1'b0;
		foreach (stk_new[i])
			stk_new[i] = 1'b0;

		add_row(ssds_pkg::OP_POP, 32'd0, 63'd0, 1'b1, depth_res(0, ssds_pkg::ERR_EMPTY));
		add_row(ssds_pkg::OP_SNAP, 32'd0, {63{1'b1}}, 1'b1, trail_res(0, 0, {63{1'b1}}));
		add_row(ssds_pkg::OP_SNAP, 32'hFFFF_FFFF, 63'd0, 1'b1, trail_res(0, 0, 63'd0));
		add_row(OP_NONE, 32'hFFFF_FFFF, {63{1'b1}}, 1'b0, '0);
		add_row(ssds_pkg::OP_PUSH, 32'hFFFF_FFFF, 63'd0, 1'b1, depth_res(1, ssds_pkg::ERR_OK));
		add_row(ssds_pkg::OP_PUSH, 32'd0, {63{1'b1}}, 1'b1, depth_res(2, ssds_pkg::ERR_OK));
		add_row(ssds_pkg::OP_PUSH, 32'hA5A5_A5A5, 63'd7, 1'b1, depth_res(3, ssds_pkg::ERR_OK));
		add_row(ssds_pkg::OP_SNAP, 32'd0, 63'h5555_5555_5555_5555, 1'b0, '0);
		add_row(ssds_pkg::OP_SNAP, 32'd0, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0);
		add_row(ssds_pkg::OP_PUSH, 32'h5A5A_5A5A, 63'd0, 1'b0, '0);
		add_row(ssds_pkg::OP_SNAP, 32'd0, 63'd1, 1'b0, '0);
		repeat (4)
			add_row(ssds_pkg::OP_POP, 32'd0, 63'd0, 1'b0, '0);
		add_row(ssds_pkg::OP_POP, 32'hFFFF_FFFF, {63{1'b1}}, 1'b1,
			depth_res(0, ssds_pkg::ERR_EMPTY));
		add_row(ssds_pkg::OP_PUSH, 32'h1234_5678, 63'd0, 1'b0, '0);
		add_row(ssds_pkg::OP_PUSH, 32'h8000_0000, 63'd0, 1'b0, '0);
		add_row(OP_NONE, 32'd0, 63'd0, 1'b0, '0);
		add_row(ssds_pkg::OP_SNAP, 32'd0, 63'h4000_0000_0000_0000, 1'b0, '0);
		add_row(ssds_pkg::OP_POP, 32'd0, 63'd0, 1'b0, '0);
		add_row(ssds_pkg::OP_SNAP, 32'd0, 63'd12345, 1'b0, '0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].op, dir_rows[i].id, dir_rows[i].ts, dir_rows[i].typed,
				dir_rows[i].res);
		sent = dir_rows.size();

		// fill past capacity, then walk every entry but the bottom one in one snapshot
		repeat (STACK_DEPTH + 2) begin
			send_cmd(ssds_pkg::OP_PUSH, rand_id(), rand_stamp(), 1'b0, '0);
			sent++;
		end
		send_cmd(ssds_pkg::OP_SNAP, rand_id(), rand_stamp(), 1'b0, '0);
		sent++;

		while (sent < NUM_ITEMS) begin
			mode = $urandom_range(3);
			len = $urandom_range(20, 4);
			repeat (len)
				if (sent < NUM_ITEMS)
					send_rand(mode, sent);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
